// File: sv/graph_random_walk_engine_macros.svh
`ifndef GRAPH_RANDOM_WALK_ENGINE_MACROS_SVH
`define GRAPH_RANDOM_WALK_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GRWE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GRWE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/grwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package grwe_pkg;

	localparam int DEF_BUFFER_DEPTH = 64;

	localparam logic [63:0] RNG_MULT  = 64'd2685821657736338717;
	localparam logic [63:0] RNG_GOLD  = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] RNG_SALT  = 64'h00000000DEADBEEF;
	localparam logic [31:0] PAD_WORD  = 32'hFFFFFFFF;

	localparam logic FUNC_TASK = 1'b0;
	localparam logic FUNC_RESP = 1'b1;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_CHUNK = 2'd1;
	localparam logic [1:0] KIND_CONT  = 2'd2;

endpackage
`default_nettype wire

// File: sv/graph_random_walk_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | valid     | stall     | beat
// ---------+-----------+-----------+-----------------------------------------------
// input    | in_valid  | in_stall  | func, task fields, read_data
// output   | out_valid | out_stall | out_kind, address, last_chunk, word0..word7
//
// A draw uses one 32x32 multiplier three times. Picking a neighbour first
// finds the rejection limit, then one remainder per accepted draw
// (one-bit-per-cycle remainder unit); each rejection costs one more draw.
// A flush makes one visited-store read per word of each chunk.
// Reset leaves the engine idle; the visited store needs no clearing.
// A stalled output holds the engine at its next emit; input is taken only while idle
// or waiting on a read response.
module graph_random_walk_engine
	import grwe_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] start_vertex,
	input  wire logic [5:0]  hop_limit,
	input  wire logic [63:0] stop_threshold,
	input  wire logic [63:0] graph_base,
	input  wire logic [63:0] out_base,
	input  wire logic [63:0] continuation,
	input  wire logic [63:0] read_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  out_kind,
	output logic      [63:0] address,
	output logic             last_chunk,
	output logic      [31:0] word0,
	output logic      [31:0] word1,
	output logic      [31:0] word2,
	output logic      [31:0] word3,
	output logic      [31:0] word4,
	output logic      [31:0] word5,
	output logic      [31:0] word6,
	output logic      [31:0] word7
);

	`include "graph_random_walk_engine_macros.svh"

	localparam int IW = $clog2(BUFFER_DEPTH);
	localparam logic [6:0] VisitCap = 7'((BUFFER_DEPTH < 64) ? BUFFER_DEPTH : 64);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DRAW, ST_MULW, ST_STEP, ST_EMIT_P, ST_EMIT_D, ST_WAIT_PTR,
		ST_WAIT_DEG, ST_LIM, ST_REJ, ST_MODW, ST_EMIT_NB, ST_WAIT_VTX,
		ST_FL_RD, ST_FL_EMIT, ST_CONT
	} state_t;

	state_t      state_q;
	logic        for_step_q;
	logic [31:0] cur_q;
	logic [5:0]  step_q;
	logic [6:0]  visited_q;
	logic [63:0] ptr_q;
	logic [5:0]  len_q;
	logic [63:0] thr_q;
	logic [63:0] gbase_q;
	logic [63:0] obase_q;
	logic [63:0] cont_q;
	logic [63:0] rng_q;
	logic [63:0] x_q;
	logic [31:0] deg_q;
	logic [63:0] limit_q;
	logic [31:0] k_q;
	logic [6:0]  base_q;
	logic [3:0]  j_q;
	logic        vld_s1;
	logic        pad_s1;
	logic [2:0]  slot_s1;
	logic [31:0] words_q [8];
	logic [31:0] ow_q [8];
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [63:0] addr_q;
	logic        last_q;

	logic        in_acc;
	logic        resp;
	logic        out_free;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] xs;
	logic [63:0] rec;
	logic        stop;
	logic [6:0]  rd_idx;
	logic        chunk_last;
	logic        mul_start;
	logic        mul_done;
	logic [63:0] mul_p;
	logic        mod_start;
	logic        mod_done;
	logic [63:0] mod_num;
	logic [31:0] mod_den;
	logic [31:0] mod_rem;
	logic        mem_we;
	logic [31:0] mem_rdata;

	assign in_stall = !(state_q == ST_IDLE || state_q == ST_WAIT_PTR ||
		state_q == ST_WAIT_DEG || state_q == ST_WAIT_VTX);
	assign in_acc   = in_valid && !in_stall;
	assign resp     = in_acc && (func == FUNC_RESP);
	assign out_free = !out_valid_q || !out_stall;

	assign t1 = rng_q ^ (rng_q >> 12);
	assign t2 = t1 ^ (t1 << 25);
	assign xs = t2 ^ (t2 >> 27);

	assign rec  = gbase_q + {28'h0, cur_q, 4'h0};
	assign stop = (x_q < thr_q) || (step_q == len_q) ||
		(({1'b0, visited_q} + 8'd1) >= {1'b0, VisitCap});
	assign rd_idx     = base_q + {4'h0, j_q[2:0]};
	assign chunk_last = ({1'b0, base_q} + 8'd8) >= {1'b0, visited_q};

	assign mul_start = (state_q == ST_DRAW);
	assign mod_start = (state_q == ST_WAIT_DEG && resp && read_data[31:0] != 32'h0) ||
		(state_q == ST_REJ && x_q < limit_q);
	assign mod_num   = (state_q == ST_REJ) ? x_q : '1;
	assign mod_den   = (state_q == ST_REJ) ? deg_q : read_data[31:0];
	assign mem_we    = (state_q == ST_STEP);

	grwe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (xs),
		.done   (mul_done),
		.p      (mul_p)
	);

	grwe_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_num),
		.divisor  (mod_den),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	grwe_mem #(
		.DEPTH (BUFFER_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (IW'(visited_q)),
		.wdata (cur_q),
		.raddr (IW'(rd_idx)),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for_step_q  <= 1'b0;
			cur_q       <= '0;
			step_q      <= '0;
			visited_q   <= '0;
			ptr_q       <= '0;
			len_q       <= '0;
			thr_q       <= '0;
			gbase_q     <= '0;
			obase_q     <= '0;
			cont_q      <= '0;
			rng_q       <= '0;
			x_q         <= '0;
			deg_q       <= '0;
			limit_q     <= '0;
			k_q         <= '0;
			base_q      <= '0;
			j_q         <= '0;
			vld_s1      <= 1'b0;
			pad_s1      <= 1'b0;
			slot_s1     <= '0;
			words_q     <= '{default: '0};
			ow_q        <= '{default: '0};
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			addr_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= out_valid_q && out_stall;
			vld_s1      <= 1'b0;
			if (vld_s1) begin
				words_q[slot_s1] <= pad_s1 ? PAD_WORD : mem_rdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && func == FUNC_TASK) begin
						cur_q      <= start_vertex;
						len_q      <= hop_limit;
						thr_q      <= stop_threshold;
						gbase_q    <= graph_base;
						obase_q    <= out_base;
						cont_q     <= continuation;
						rng_q      <= (RNG_SALT ^ {32'h0, start_vertex}) + RNG_GOLD;
						visited_q  <= '0;
						step_q     <= '0;
						ptr_q      <= '0;
						for_step_q <= 1'b1;
						state_q    <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					rng_q   <= xs;
					state_q <= ST_MULW;
				end
				ST_MULW: begin
					if (mul_done) begin
						x_q     <= mul_p;
						state_q <= for_step_q ? ST_STEP : ST_REJ;
					end
				end
				ST_STEP: begin
					visited_q <= visited_q + 7'd1;
					if (stop) begin
						base_q  <= '0;
						j_q     <= '0;
						state_q <= ST_FL_RD;
					end else begin
						state_q <= ST_EMIT_P;
					end
				end
				ST_EMIT_P: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_READ;
						addr_q      <= rec;
						last_q      <= 1'b0;
						ow_q        <= '{default: '0};
						state_q     <= ST_EMIT_D;
					end
				end
				ST_EMIT_D: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_READ;
						addr_q      <= rec + 64'd8;
						last_q      <= 1'b0;
						ow_q        <= '{default: '0};
						state_q     <= ST_WAIT_PTR;
					end
				end
				ST_WAIT_PTR: begin
					if (resp) begin
						ptr_q   <= read_data;
						state_q <= ST_WAIT_DEG;
					end
				end
				ST_WAIT_DEG: begin
					if (resp) begin
						deg_q <= read_data[31:0];
						if (read_data[31:0] == 32'h0) begin
							base_q  <= '0;
							j_q     <= '0;
							state_q <= ST_FL_RD;
						end else begin
							state_q <= ST_LIM;
						end
					end
				end
				ST_LIM: begin
					if (mod_done) begin
						// largest multiple of the degree that fits in 64 bits
						limit_q    <= '1 - {32'h0, mod_rem};
						for_step_q <= 1'b0;
						state_q    <= ST_DRAW;
					end
				end
				ST_REJ: begin
					state_q <= (x_q < limit_q) ? ST_MODW : ST_DRAW;
				end
				ST_MODW: begin
					if (mod_done) begin
						k_q     <= mod_rem;
						state_q <= ST_EMIT_NB;
					end
				end
				ST_EMIT_NB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_READ;
						addr_q      <= ptr_q + {30'h0, k_q, 2'b00};
						last_q      <= 1'b0;
						ow_q        <= '{default: '0};
						state_q     <= ST_WAIT_VTX;
					end
				end
				ST_WAIT_VTX: begin
					if (resp) begin
						cur_q      <= read_data[31:0];
						step_q     <= step_q + 6'd1;
						for_step_q <= 1'b1;
						state_q    <= ST_DRAW;
					end
				end
				ST_FL_RD: begin
					if (j_q[3]) begin
						state_q <= ST_FL_EMIT;
					end else begin
						vld_s1  <= 1'b1;
						pad_s1  <= rd_idx >= visited_q;
						slot_s1 <= j_q[2:0];
						j_q     <= j_q + 4'd1;
					end
				end
				ST_FL_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_CHUNK;
						addr_q      <= obase_q + {55'h0, base_q, 2'b00};
						last_q      <= chunk_last;
						ow_q        <= words_q;
						if (chunk_last) begin
							state_q <= ST_CONT;
						end else begin
							base_q  <= base_q + 7'd8;
							j_q     <= '0;
							state_q <= ST_FL_RD;
						end
					end
				end
				ST_CONT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_CONT;
						addr_q      <= cont_q;
						last_q      <= 1'b0;
						ow_q        <= '{default: '0};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign address    = addr_q;
	assign last_chunk = last_q;
	assign word0      = ow_q[0];
	assign word1      = ow_q[1];
	assign word2      = ow_q[2];
	assign word3      = ow_q[3];
	assign word4      = ow_q[4];
	assign word5      = ow_q[5];
	assign word6      = ow_q[6];
	assign word7      = ow_q[7];

	`GRWE_ASSERT_NOW(a_mul_done_state, mul_done, state_q == ST_MULW, "multiplier done outside draw wait")
	`GRWE_ASSERT_NOW(a_mod_done_state, mod_done, state_q == ST_LIM || state_q == ST_MODW, "remainder done outside its wait")
	`GRWE_ASSERT_NOW(a_visit_cap, 1'b1, visited_q <= VisitCap, "visited count above cap")
	`GRWE_ASSERT_NEXT(a_step_count, state_q == ST_STEP, visited_q == $past(visited_q) + 7'd1, "visited count did not advance")

endmodule
`default_nettype wire

// File: sv/grwe_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module grwe_mem
	import grwe_pkg::*;
#(
	parameter int DEPTH = DEF_BUFFER_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [31:0]              wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/grwe_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module grwe_mul
	import grwe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	output logic             done,
	output logic      [63:0] p
);

	// low 64 bits of a * RNG_MULT from three 32x32 partial products
	logic [63:0] a_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        run_q;
	logic        sh_q;
	logic        done_q;
	logic [31:0] opa;
	logic [31:0] opb;

	always_comb begin
		case (step_q)
			2'd0:    begin opa = a_q[31:0];  opb = RNG_MULT[31:0];  end
			2'd1:    begin opa = a_q[31:0];  opb = RNG_MULT[63:32]; end
			2'd2:    begin opa = a_q[63:32]; opb = RNG_MULT[31:0];  end
			default: begin opa = '0;         opb = '0;              end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			prod_q <= '0;
			acc_q  <= '0;
			step_q <= '0;
			run_q  <= 1'b0;
			sh_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				acc_q  <= '0;
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				if (step_q != 2'd3) begin
					prod_q <= {32'h0, opa} * {32'h0, opb};
					sh_q   <= (step_q != 2'd0);
					step_q <= step_q + 2'd1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				if (step_q != 2'd0) begin
					acc_q <= acc_q + (sh_q ? {prod_q[31:0], 32'h0} : prod_q);
				end
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule
`default_nettype wire

// File: sv/grwe_mod.sv
`timescale 1ns / 1ps
`default_nettype none
module grwe_mod (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic      [31:0] rem
);

	// restoring remainder, one dividend bit per cycle
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, num_q[63]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= dividend;
				den_q <= divisor;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				num_q <= {num_q[62:0], 1'b0};
				rem_q <= diff[32] ? trial[31:0] : diff[31:0];
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// File: verif/graph_random_walk_engine_tb.sv
`timescale 1ns / 1ps
module graph_random_walk_engine_tb;
	import grwe_pkg::*;

	localparam int VISIT_MAX = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef enum logic [1:0] {WALK_IDLE, WALK_PTR, WALK_DEG, WALK_VTX} walk_phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [63:0]      addr;
		logic             last;
		logic [7:0][31:0] words;
	} walk_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = FUNC_TASK;
	logic [31:0] start_vertex = '0;
	logic [5:0] hop_limit = '0;
	logic [63:0] stop_threshold = '0;
	logic [63:0] graph_base = '0;
	logic [63:0] out_base = '0;
	logic [63:0] continuation = '0;
	logic [63:0] read_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] out_kind;
	logic [63:0] address;
	logic last_chunk;
	logic [31:0] word0, word1, word2, word3, word4, word5, word6, word7;

	graph_random_walk_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .start_vertex(start_vertex), .hop_limit(hop_limit),
		.stop_threshold(stop_threshold), .graph_base(graph_base), .out_base(out_base),
		.continuation(continuation), .read_data(read_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_kind(out_kind), .address(address), .last_chunk(last_chunk),
		.word0(word0), .word1(word1), .word2(word2), .word3(word3),
		.word4(word4), .word5(word5), .word6(word6), .word7(word7)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// walk predictor state
	logic [63:0] rng_st;
	walk_phase_t walk_ph;
	logic [31:0] cur_vertex;
	logic [5:0] hop_idx;
	int unsigned visit_cnt;
	logic [63:0] nbr_ptr;
	logic [31:0] visit_log [VISIT_MAX];
	logic [5:0] job_len;
	logic [63:0] job_thr, job_gbase, job_obase, job_cont;

	walk_beat_t expected_q[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int walks_done = 0;
	bit no_gaps = 1'b0;
	bit out_took = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] draw_rng();
		logic [63:0] x;
		x = rng_st;
		x ^= x >> 12;
		x ^= x << 25;
		x ^= x >> 27;
		rng_st = x;
		return x * RNG_MULT;
	endfunction

	function automatic void push_beat(logic [1:0] kind, logic [63:0] addr, logic last,
			logic [7:0][31:0] words);
		walk_beat_t b;
		b.kind = kind;
		b.addr = addr;
		b.last = last;
		b.words = words;
		expected_q.push_back(b);
	endfunction

	function automatic void flush_walk();
		logic [7:0][31:0] w;
		int unsigned idx;
		for (int unsigned base = 0; base < visit_cnt; base += 8) begin
			for (int j = 0; j < 8; j++) begin
				idx = base + j;
				w[j] = (idx < VISIT_MAX) ? visit_log[idx] : PAD_WORD;
			end
			push_beat(KIND_CHUNK, job_obase + 64'(base) * 64'd4, (base + 8 >= visit_cnt), w);
		end
		push_beat(KIND_CONT, job_cont, 1'b0, '0);
		walk_ph = WALK_IDLE;
		walks_done++;
	endfunction

	function automatic void walk_step();
		logic stop;
		logic [63:0] rec;
		stop = draw_rng() < job_thr;
		if (hop_idx == job_len || visit_cnt + 1 >= VISIT_MAX)
			stop = 1'b1;
		if (visit_cnt < VISIT_MAX)
			visit_log[visit_cnt] = cur_vertex;
		visit_cnt++;
		if (stop) begin
			flush_walk();
		end else begin
			rec = job_gbase + {28'd0, cur_vertex, 4'd0};
			push_beat(KIND_READ, rec, 1'b0, '0);
			push_beat(KIND_READ, rec + 64'd8, 1'b0, '0);
			walk_ph = WALK_PTR;
		end
	endfunction

	function automatic void predict_beat();
		logic [31:0] deg;
		logic [63:0] lim, x;
		if (func == FUNC_TASK) begin
			if (walk_ph != WALK_IDLE)
				return;
			cur_vertex = start_vertex;
			job_len = hop_limit;
			job_thr = stop_threshold;
			job_gbase = graph_base;
			job_obase = out_base;
			job_cont = continuation;
			rng_st = (RNG_SALT ^ {32'd0, start_vertex}) + RNG_GOLD;
			for (int i = 0; i < VISIT_MAX; i++)
				visit_log[i] = PAD_WORD;
			visit_cnt = 0;
			hop_idx = '0;
			nbr_ptr = '0;
			walk_step();
			return;
		end
		case (walk_ph)
			WALK_PTR: begin
				nbr_ptr = read_data;
				walk_ph = WALK_DEG;
			end
			WALK_DEG: begin
				deg = read_data[31:0];
				if (deg == 0) begin
					flush_walk();
				end else begin
					lim = (64'hFFFF_FFFF_FFFF_FFFF / {32'd0, deg}) * {32'd0, deg};
					do x = draw_rng(); while (x >= lim);
					push_beat(KIND_READ, nbr_ptr + (x % {32'd0, deg}) * 64'd4, 1'b0, '0);
					walk_ph = WALK_VTX;
				end
			end
			WALK_VTX: begin
				cur_vertex = read_data[31:0];
				hop_idx = hop_idx + 6'd1;
				walk_step();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(logic f, logic [31:0] sv, logic [5:0] wl, logic [63:0] thr,
			logic [63:0] gb, logic [63:0] ob, logic [63:0] ct, logic [63:0] rd);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		start_vertex = sv;
		hop_limit = wl;
		stop_threshold = thr;
		graph_base = gb;
		out_base = ob;
		continuation = ct;
		read_data = rd;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		predict_beat();
	endtask

	task automatic send_task(logic [31:0] sv, logic [5:0] wl, logic [63:0] thr);
		send_beat(FUNC_TASK, sv, wl, thr, rand64(), rand64(), rand64(), rand64());
	endtask

	// answer reads until the walk ends; deg_mode picks the degree per hop
	task automatic run_walk(int deg_mode, bit noise);
		logic [63:0] rd;
		while (walk_ph != WALK_IDLE) begin
			rd = rand64();
			if (walk_ph == WALK_DEG) begin
				case (deg_mode)
					0: rd[31:0] = $urandom_range(1, 8);
					1: rd[31:0] = 32'hFFFF_FFFF;
					2: rd[31:0] = 32'd1;
					3: rd[31:0] = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 20);
					default: rd[31:0] = $urandom | 32'h8000_0001;
				endcase
			end
			if (noise && $urandom_range(0, 7) == 0)
				send_task($urandom, 6'($urandom), rand64());
			send_beat(FUNC_RESP, $urandom, 6'($urandom), rand64(), rand64(), rand64(),
				rand64(), rd);
		end
	endtask

	task automatic test_no_hops();
		send_task(32'd0, 6'd0, 64'd0);
		run_walk(0, 0);
		send_task(32'hFFFF_FFFF, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		run_walk(0, 0);
	endtask

	task automatic test_zero_degree();
		send_task($urandom, 6'd63, 64'd0);
		send_beat(FUNC_RESP, '0, '0, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(FUNC_RESP, '0, '0, '0, '0, '0, '0, 64'hFFFF_FFFF_0000_0000);
		run_walk(0, 0);
	endtask

	task automatic test_degree_extremes();
		send_task($urandom, 6'd3, 64'd0);
		run_walk(1, 0);
		send_task($urandom, 6'd3, 64'd0);
		run_walk(2, 0);
		send_task($urandom, 6'd4, 64'd0);
		run_walk(4, 0);
	endtask

	task automatic test_full_buffer();
		no_gaps = 1'b1;
		send_beat(FUNC_TASK, 32'hFFFF_FFFF, 6'd63, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		run_walk(0, 0);
		no_gaps = 1'b0;
	endtask

	task automatic test_wrong_phase();
		send_beat(FUNC_RESP, $urandom, 6'($urandom), rand64(), rand64(), rand64(), rand64(),
			rand64());
		send_task($urandom, 6'd5, 64'd0);
		run_walk(0, 1);
	endtask

	task automatic test_random_walks();
		logic [63:0] thr;
		while (beats_sent < 260) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: thr = 64'd0;
				1: thr = rand64() >> $urandom_range(2, 63);
				2: thr = rand64();
				default: thr = 64'hFFFF_FFFF_FFFF_FFFF;
			endcase
			if ($urandom_range(0, 9) == 0)
				send_beat(FUNC_RESP, $urandom, 6'($urandom), rand64(), rand64(), rand64(),
					rand64(), rand64());
			send_task($urandom, ($urandom_range(0, 7) == 0) ? 6'($urandom) :
				6'($urandom_range(0, 6)), thr);
			run_walk($urandom_range(0, 4), $urandom_range(0, 3) == 0);
		end
		no_gaps = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		logic [7:0][31:0] got;
		walk_beat_t exp_b;
		out_took = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			out_took = 1'b1;
			got = {word7, word6, word5, word4, word3, word2, word1, word0};
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: kind %0d address %h", out_kind, address);
				errors++;
			end else begin
				exp_b = expected_q.pop_front();
				beats_checked++;
				if (out_kind !== exp_b.kind) begin
					$error("out_kind expected %0d got %0d", exp_b.kind, out_kind);
					errors++;
				end
				if (address !== exp_b.addr) begin
					$error("address expected %h got %h", exp_b.addr, address);
					errors++;
				end
				if (last_chunk !== exp_b.last) begin
					$error("last_chunk expected %0d got %0d", exp_b.last, last_chunk);
					errors++;
				end
				for (int j = 0; j < 8; j++)
					if (got[j] !== exp_b.words[j]) begin
						$error("word%0d expected %h got %h", j, exp_b.words[j], got[j]);
						errors++;
					end
			end
		end
	end

	// receiver stall: draw a new hold after every taken beat
	always @(negedge clk) begin
		if (out_took)
			stall_left = no_gaps ? 0 : $urandom_range(0, 12);
		out_stall <= (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		rng_st = '0;
		walk_ph = WALK_IDLE;
		cur_vertex = '0;
		hop_idx = '0;
		visit_cnt = 0;
		nbr_ptr = '0;
		job_len = '0;
		job_thr = '0;
		job_gbase = '0;
		job_obase = '0;
		job_cont = '0;
		for (int i = 0; i < VISIT_MAX; i++)
			visit_log[i] = PAD_WORD;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_no_hops();
		test_zero_degree();
		test_degree_extremes();
		test_full_buffer();
		test_wrong_phase();
		test_random_walks();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d input beats in %0d walks, %0d result beats checked",
			beats_sent, walks_done, beats_checked);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/grwe_pkg.sv
sv/grwe_mem.sv
sv/grwe_mul.sv
sv/grwe_mod.sv
sv/graph_random_walk_engine.sv
verif/graph_random_walk_engine_tb.sv
